>>> hdl/wms_pkg.sv
package wms_pkg;

  localparam int unsigned MAX_COUNT = 32;
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned USED_W    = 6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median_value;
    logic [USED_W-1:0]          used_count;
    logic                       overflow;
  } out_item_t;

  // Broadcast control that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic                       insert;
    logic                       shift;
    logic signed [SAMPLE_W-1:0] key;
  } cell_ctrl_t;

endpackage

>>> hdl/window_median_select.sv
// Window median selector. Samples of a window (signed Q16.16) enter one per
// cycle and are kept in ascending order by a chain of MaxCount insertion
// cells: every cell compares the new sample against its own value in
// parallel and either keeps its value, takes its lower neighbor's value, or
// takes the new sample. The item that carries last is placed like any other
// and then closes the window. The chain is then shifted down toward cell 0
// until cell 0 (and cell 1 for an even count of stored samples) hold the
// middle pair; the median, averaging the middle pair rounded toward minus
// infinity for an even count, is then formed into the output register. The
// input stalls during the drain and while a finished result still waits in
// the output register when the next drain completes. Samples arriving while
// the chain holds MaxCount entries are dropped and flagged in overflow;
// used_count is the stored count kept to its low 6 bits.
module window_median_select #(
  parameter int unsigned MaxCount = wms_pkg::MAX_COUNT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wms_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wms_pkg::out_item_t  out_item_o
);
  import wms_pkg::*;

  localparam int unsigned CntW = $clog2(MaxCount + 1);

  typedef enum logic [0:0] {
    ST_FILL,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   fill_count_q;
  logic [CntW-1:0]   drain_cnt_q;
  logic              dropped_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_accept;
  logic              full;
  logic              drain_done;
  logic              out_free;
  cell_ctrl_t        ctrl;

  logic signed [SAMPLE_W-1:0] cell_value [MaxCount+1];
  logic                       cell_greater [MaxCount];
  logic                       cell_occupied [MaxCount];

  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W-1:0] median;
  logic [CntW-1:0]            count_after;

  assign in_stall_o = (state_q != ST_FILL);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (fill_count_q == CntW'(MaxCount));
  assign drain_done = (state_q == ST_DRAIN) && (drain_cnt_q == '0);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    ctrl.insert = in_accept && !full;
    ctrl.shift  = (state_q == ST_DRAIN) && (drain_cnt_q != '0);
    ctrl.key    = in_item_i.sample;
  end

  // The insertion chain. Cell 0 holds the smallest sample.
  for (genvar i = 0; i < MaxCount; i++) begin : g_cell
    assign cell_occupied[i] = (fill_count_q > CntW'(i));

    if (i == 0) begin : g_first
      wms_cell u_cell (
        .clk_i           (clk_i),
        .ctrl_i          (ctrl),
        .occupied_i      (cell_occupied[i]),
        .left_occupied_i (1'b1),
        .left_greater_i  (1'b0),
        .left_value_i    (in_item_i.sample),
        .right_value_i   (cell_value[i+1]),
        .value_o         (cell_value[i]),
        .greater_o       (cell_greater[i])
      );
    end else begin : g_rest
      wms_cell u_cell (
        .clk_i           (clk_i),
        .ctrl_i          (ctrl),
        .occupied_i      (cell_occupied[i]),
        .left_occupied_i (cell_occupied[i-1]),
        .left_greater_i  (cell_greater[i-1]),
        .left_value_i    (cell_value[i-1]),
        .right_value_i   (cell_value[i+1]),
        .value_o         (cell_value[i]),
        .greater_o       (cell_greater[i])
      );
    end
  end

  // The cell past the top of the chain feeds zeros during the drain.
  assign cell_value[MaxCount] = '0;

  // After the drain, cell 0 holds the lower middle sample and cell 1 the
  // upper one of an even count. The mean's floor is an arithmetic shift.
  assign pair_sum = {cell_value[0][SAMPLE_W-1], cell_value[0]}
                  + {cell_value[1][SAMPLE_W-1], cell_value[1]};
  assign median   = fill_count_q[0] ? cell_value[0] : pair_sum[SAMPLE_W:1];

  assign count_after = full ? fill_count_q : fill_count_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      fill_count_q <= '0;
      drain_cnt_q  <= '0;
      dropped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if (drain_done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_FILL: begin
          if (in_accept) begin
            fill_count_q <= count_after;
            if (full) begin
              dropped_q <= 1'b1;
            end
            if (in_item_i.last) begin
              drain_cnt_q <= (count_after - CntW'(1)) >> 1;
              state_q     <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (drain_cnt_q != '0) begin
            drain_cnt_q <= drain_cnt_q - CntW'(1);
          end else if (out_free) begin
            fill_count_q <= '0;
            dropped_q    <= 1'b0;
            state_q      <= ST_FILL;
          end
        end
        default: state_q <= ST_FILL;
      endcase
    end
  end

  // Output payload register; loaded when the drain completes.
  always_ff @(posedge clk_i) begin
    if (drain_done && out_free) begin
      out_q.median_value <= median;
      out_q.used_count   <= USED_W'(fill_count_q);
      out_q.overflow     <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_count_q <= CntW'(MaxCount))
    else $error("fill count beyond chain length");

  a_drop_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> full)
    else $error("drop flag set with free cells");

  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.last |=> state_q == ST_DRAIN)
    else $error("window close did not start a drain");

  a_result_from_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(drain_done))
    else $error("result appeared without a finished drain");

  a_window_empty_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> fill_count_q == '0 && !dropped_q)
    else $error("window not emptied after result");
`endif

endmodule

>>> hdl/wms_cell.sv
module wms_cell (
  input  logic                               clk_i,
  input  wms_pkg::cell_ctrl_t                ctrl_i,
  input  logic                               occupied_i,
  input  logic                               left_occupied_i,
  input  logic                               left_greater_i,
  input  logic signed [wms_pkg::SAMPLE_W-1:0] left_value_i,
  input  logic signed [wms_pkg::SAMPLE_W-1:0] right_value_i,
  output logic signed [wms_pkg::SAMPLE_W-1:0] value_o,
  output logic                               greater_o
);
  import wms_pkg::*;

  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic                       load;

  // Strictly greater, so an equal key lands after the samples already held.
  assign greater_o = occupied_i && (value_q > ctrl_i.key);
  // A cell loads when its value moves up, or when it is the first free cell.
  assign load      = greater_o || (!occupied_i && left_occupied_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = right_value_i;
    end else if (ctrl_i.insert && load) begin
      value_d = left_greater_i ? left_value_i : ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
